FILE: rtl/core/fbbf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the flat-bottom bond force pipeline.
// Depends on nothing; used by flat_bottom_bond_force_core.
package fbbf_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_STIFFNESS_TYPE0  = 3'd0;
   localparam logic [2:0] CSR_OUTER_WALL_TYPE0 = 3'd1;
   localparam logic [2:0] CSR_INNER_WALL_TYPE0 = 3'd2;
   localparam logic [2:0] CSR_STIFFNESS_TYPE1  = 3'd3;
   localparam logic [2:0] CSR_OUTER_WALL_TYPE1 = 3'd4;
   localparam logic [2:0] CSR_INNER_WALL_TYPE1 = 3'd5;
   localparam logic [2:0] CSR_SPECIAL_OUTER    = 3'd6;

   localparam logic [31:0] SPECIAL_OUTER_RESET = 32'd32768;
   localparam logic signed [7:0] SPIN_POS_FOUR = 8'sd4;
   localparam logic signed [7:0] SPIN_NEG_FOUR = -8'sd4;

   // Pipeline layout.
   localparam int SQRT_BITS  = 34;
   localparam int QUOT_BITS  = 32;
   localparam int ST_IN      = 0;
   localparam int ST_SQ      = 1;
   localparam int ST_SUM     = 2;
   localparam int ST_SQRT0   = 3;
   localparam int ST_WALL    = ST_SQRT0 + SQRT_BITS;
   localparam int ST_M1      = ST_WALL + 1;
   localparam int ST_M2      = ST_M1 + 1;
   localparam int ST_M3      = ST_M2 + 1;
   localparam int ST_OVF     = ST_M3 + 1;
   localparam int ST_DIV0    = ST_OVF + 1;
   localparam int ST_OUT     = ST_DIV0 + QUOT_BITS;
   localparam int NUM_STAGES = ST_OUT + 1;

   typedef struct packed {
      logic [2:0][32:0] ax;      // |first - second| per axis
      logic [2:0]       dpos;    // axis difference strictly positive
      logic [31:0]      k;
      logic [31:0]      rmax;
      logic [31:0]      rmin;
      logic             last;
      logic [2:0][65:0] sq;
      logic [67:0]      rem;     // square root remainder
      logic [33:0]      root;
      logic             well;
      logic             zero;
      logic             drpos;
      logic [33:0]      adr;
      logic [65:0]      kd;
      logic [67:0]      adr2;
      logic [2:0][65:0] plo;
      logic [2:0][65:0] phi;
      logic [65:0]      elo;
      logic [65:0]      ehi;
      logic [2:0][98:0] num;     // dividend, then division remainder
      logic [48:0]      den;
      logic [31:0]      energy;
      logic [2:0]       ovf;
      logic [2:0][31:0] quo;
      logic [2:0][31:0] force_out;
   } pipe_type;

endpackage

FILE: rtl/core/flat_bottom_bond_force_core.sv
`timescale 1ns / 1ps
// Flat-bottom harmonic bond force core: one bond in, one force/energy result out.
// Depends on fbbf_pkg for the stage record, stage layout and register indexes.
//
// Pipeline: 75 register stages (one stage per square root bit and per quotient bit).
// Throughput: one bond per cycle while the result side does not stall.
// A stall on the result side freezes the whole pipeline in one step.
// Reset (synchronous, active high) clears all valid bits and loads the register
// reset values; payload stages are not reset.
module flat_bottom_bond_force_core (
   input  logic          clock,
   input  logic          reset,
   // Bond input channel.
   input  logic          req_tvalid,
   output logic          req_tready,
   // [31:0] first_x, [63:32] first_y, [95:64] first_z, [127:96] second_x,
   // [159:128] second_y, [191:160] second_z, [199:192] first_spin,
   // [207:200] second_spin
   input  logic [207:0]  req_tdata,
   input  logic          req_tuser,   // [0] bond_type
   input  logic          req_tlast,   // final_bond
   // Result channel.
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [31:0] force_x, [63:32] force_y, [95:64] force_z, [127:96] bond_energy
   output logic [127:0]  rsp_tdata,
   output logic [1:0]    rsp_tuser,   // [0] in_well, [1] zero_length
   output logic          rsp_tlast,   // final_out
   // Configuration write port.
   input  logic          csr_we,
   input  logic [2:0]    csr_addr,
   input  logic [31:0]   csr_wdata
);

   localparam int LAST = fbbf_pkg::NUM_STAGES - 1;

   // Configuration registers.
   logic [6:0][31:0] cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            fbbf_pkg::CSR_STIFFNESS_TYPE0:  cfg_in[0] = csr_wdata;
            fbbf_pkg::CSR_OUTER_WALL_TYPE0: cfg_in[1] = csr_wdata;
            fbbf_pkg::CSR_INNER_WALL_TYPE0: cfg_in[2] = csr_wdata;
            fbbf_pkg::CSR_STIFFNESS_TYPE1:  cfg_in[3] = csr_wdata;
            fbbf_pkg::CSR_OUTER_WALL_TYPE1: cfg_in[4] = csr_wdata;
            fbbf_pkg::CSR_INNER_WALL_TYPE1: cfg_in[5] = csr_wdata;
            fbbf_pkg::CSR_SPECIAL_OUTER:    cfg_in[6] = csr_wdata;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= {fbbf_pkg::SPECIAL_OUTER_RESET, {6{32'b0}}};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fbbf_pkg::pipe_type st_ff [fbbf_pkg::NUM_STAGES];
   fbbf_pkg::pipe_type st_in [fbbf_pkg::NUM_STAGES];
   logic [LAST:0]      vld_ff;

   // The pipeline advances as a whole whenever the output stage is empty or
   // its result is being taken; bubbles inside the pipe are carried along.
   logic adv;
   assign adv        = !vld_ff[LAST] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAST-1:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   // Stage 0: axis differences, their magnitudes, coefficient selection.
   always_comb begin
      logic signed [32:0] d;
      logic signed [7:0]  s1;
      logic signed [7:0]  s2;
      logic               special;
      logic               t;
      st_in[fbbf_pkg::ST_IN] = '0;
      for (int a = 0; a < 3; a++) begin
         d = {req_tdata[32*a+31], req_tdata[32*a +: 32]}
           - {req_tdata[32*a+127], req_tdata[32*a+96 +: 32]};
         st_in[fbbf_pkg::ST_IN].ax[a]   = d[32] ? 33'(-d) : 33'(d);
         st_in[fbbf_pkg::ST_IN].dpos[a] = !d[32] && (d != '0);
      end
      s1 = req_tdata[199:192];
      s2 = req_tdata[207:200];
      special = (s1 == fbbf_pkg::SPIN_POS_FOUR) || (s1 == fbbf_pkg::SPIN_NEG_FOUR)
             || (s2 == fbbf_pkg::SPIN_POS_FOUR) || (s2 == fbbf_pkg::SPIN_NEG_FOUR);
      t = req_tuser;
      st_in[fbbf_pkg::ST_IN].k    = t ? cfg_ff[3] : cfg_ff[0];
      st_in[fbbf_pkg::ST_IN].rmax = special ? cfg_ff[6] : (t ? cfg_ff[4] : cfg_ff[1]);
      st_in[fbbf_pkg::ST_IN].rmin = t ? cfg_ff[5] : cfg_ff[2];
      st_in[fbbf_pkg::ST_IN].last = req_tlast;
   end

   // Squares of the axis magnitudes.
   always_comb begin
      st_in[fbbf_pkg::ST_SQ] = st_ff[fbbf_pkg::ST_SQ-1];
      for (int a = 0; a < 3; a++) begin
         st_in[fbbf_pkg::ST_SQ].sq[a] = {33'b0, st_ff[fbbf_pkg::ST_SQ-1].ax[a]}
                                      * {33'b0, st_ff[fbbf_pkg::ST_SQ-1].ax[a]};
      end
   end

   // Squared length; it seeds the square root remainder.
   always_comb begin
      st_in[fbbf_pkg::ST_SUM] = st_ff[fbbf_pkg::ST_SUM-1];
      st_in[fbbf_pkg::ST_SUM].rem = {2'b0, st_ff[fbbf_pkg::ST_SUM-1].sq[0]}
                                  + {2'b0, st_ff[fbbf_pkg::ST_SUM-1].sq[1]}
                                  + {2'b0, st_ff[fbbf_pkg::ST_SUM-1].sq[2]};
      st_in[fbbf_pkg::ST_SUM].root = '0;
   end

   // Integer square root, one result bit per stage, most significant first.
   // Setting bit b adds (root << (b+1)) + 2^(2b) to the square.
   for (genvar j = 0; j < fbbf_pkg::SQRT_BITS; j++) begin : g_sqrt
      localparam int B = fbbf_pkg::SQRT_BITS - 1 - j;
      localparam int N = fbbf_pkg::ST_SQRT0 + j;
      always_comb begin
         logic [67:0] trial;
         st_in[N] = st_ff[N-1];
         trial = (68'(st_ff[N-1].root) << (B + 1)) | (68'(1) << (2 * B));
         if (st_ff[N-1].rem >= trial) begin
            st_in[N].rem     = st_ff[N-1].rem - trial;
            st_in[N].root[B] = 1'b1;
         end
      end
   end

   // Wall test: inside the well, beyond the outer wall or short of the inner.
   always_comb begin
      logic [33:0] r;
      logic [33:0] rmax;
      logic [33:0] rmin;
      st_in[fbbf_pkg::ST_WALL] = st_ff[fbbf_pkg::ST_WALL-1];
      r    = st_ff[fbbf_pkg::ST_WALL-1].root;
      rmax = {2'b0, st_ff[fbbf_pkg::ST_WALL-1].rmax};
      rmin = {2'b0, st_ff[fbbf_pkg::ST_WALL-1].rmin};
      st_in[fbbf_pkg::ST_WALL].well  = (r < rmax) && (r > rmin);
      st_in[fbbf_pkg::ST_WALL].drpos = (r > rmax);
      st_in[fbbf_pkg::ST_WALL].zero  = (r == '0);
      if ((r < rmax) && (r > rmin)) begin
         st_in[fbbf_pkg::ST_WALL].adr = '0;
      end else if (r > rmax) begin
         st_in[fbbf_pkg::ST_WALL].adr = r - rmax;
      end else if (r < rmin) begin
         st_in[fbbf_pkg::ST_WALL].adr = rmin - r;
      end else begin
         st_in[fbbf_pkg::ST_WALL].adr = '0;
      end
   end

   // k*|dr| for the force and |dr|^2 for the energy.
   always_comb begin
      st_in[fbbf_pkg::ST_M1] = st_ff[fbbf_pkg::ST_M1-1];
      st_in[fbbf_pkg::ST_M1].kd   = {34'b0, st_ff[fbbf_pkg::ST_M1-1].k}
                                  * {32'b0, st_ff[fbbf_pkg::ST_M1-1].adr};
      st_in[fbbf_pkg::ST_M1].adr2 = {34'b0, st_ff[fbbf_pkg::ST_M1-1].adr}
                                  * {34'b0, st_ff[fbbf_pkg::ST_M1-1].adr};
   end

   // Partial products: the wide operands are split in two halves.
   always_comb begin
      st_in[fbbf_pkg::ST_M2] = st_ff[fbbf_pkg::ST_M2-1];
      for (int a = 0; a < 3; a++) begin
         st_in[fbbf_pkg::ST_M2].plo[a] = {33'b0, st_ff[fbbf_pkg::ST_M2-1].kd[32:0]}
                                       * {33'b0, st_ff[fbbf_pkg::ST_M2-1].ax[a]};
         st_in[fbbf_pkg::ST_M2].phi[a] = {33'b0, st_ff[fbbf_pkg::ST_M2-1].kd[65:33]}
                                       * {33'b0, st_ff[fbbf_pkg::ST_M2-1].ax[a]};
      end
      st_in[fbbf_pkg::ST_M2].elo = {32'b0, st_ff[fbbf_pkg::ST_M2-1].adr2[33:0]}
                                 * {34'b0, st_ff[fbbf_pkg::ST_M2-1].k};
      st_in[fbbf_pkg::ST_M2].ehi = {32'b0, st_ff[fbbf_pkg::ST_M2-1].adr2[67:34]}
                                 * {34'b0, st_ff[fbbf_pkg::ST_M2-1].k};
   end

   // Recombine the halves; saturate the energy; form the divisor r * 2^15.
   always_comb begin
      logic [99:0] e;
      st_in[fbbf_pkg::ST_M3] = st_ff[fbbf_pkg::ST_M3-1];
      for (int a = 0; a < 3; a++) begin
         st_in[fbbf_pkg::ST_M3].num[a] = {33'b0, st_ff[fbbf_pkg::ST_M3-1].plo[a]}
                                       + {st_ff[fbbf_pkg::ST_M3-1].phi[a], 33'b0};
      end
      e = {34'b0, st_ff[fbbf_pkg::ST_M3-1].elo} + {st_ff[fbbf_pkg::ST_M3-1].ehi, 34'b0};
      st_in[fbbf_pkg::ST_M3].energy = (e[99:64] != '0) ? '1 : e[63:32];
      st_in[fbbf_pkg::ST_M3].den    = {st_ff[fbbf_pkg::ST_M3-1].root, 15'b0};
   end

   // A quotient of 2^32 or more always saturates, so only 32 bits are divided.
   always_comb begin
      st_in[fbbf_pkg::ST_OVF] = st_ff[fbbf_pkg::ST_OVF-1];
      for (int a = 0; a < 3; a++) begin
         st_in[fbbf_pkg::ST_OVF].ovf[a] = st_ff[fbbf_pkg::ST_OVF-1].num[a]
                                        >= {18'b0, st_ff[fbbf_pkg::ST_OVF-1].den, 32'b0};
         st_in[fbbf_pkg::ST_OVF].quo[a] = '0;
      end
   end

   // Restoring division, one quotient bit per stage in each of three lanes.
   for (genvar j = 0; j < fbbf_pkg::QUOT_BITS; j++) begin : g_div
      localparam int I = fbbf_pkg::QUOT_BITS - 1 - j;
      localparam int N = fbbf_pkg::ST_DIV0 + j;
      always_comb begin
         logic [98:0] dsh;
         st_in[N] = st_ff[N-1];
         dsh = {50'b0, st_ff[N-1].den} << I;
         for (int a = 0; a < 3; a++) begin
            if (st_ff[N-1].num[a] >= dsh) begin
               st_in[N].num[a]    = st_ff[N-1].num[a] - dsh;
               st_in[N].quo[a][I] = 1'b1;
            end
         end
      end
   end

   // Sign and saturation. The force points against dr along each axis; a zero
   // length bond has no direction and gives no force.
   always_comb begin
      logic neg;
      logic [31:0] q;
      st_in[fbbf_pkg::ST_OUT] = st_ff[fbbf_pkg::ST_OUT-1];
      for (int a = 0; a < 3; a++) begin
         neg = (st_ff[fbbf_pkg::ST_OUT-1].drpos == st_ff[fbbf_pkg::ST_OUT-1].dpos[a]);
         q   = st_ff[fbbf_pkg::ST_OUT-1].quo[a];
         if (st_ff[fbbf_pkg::ST_OUT-1].zero) begin
            st_in[fbbf_pkg::ST_OUT].force_out[a] = '0;
         end else if (neg) begin
            if (st_ff[fbbf_pkg::ST_OUT-1].ovf[a] || q > 32'h8000_0000) begin
               st_in[fbbf_pkg::ST_OUT].force_out[a] = 32'h8000_0000;
            end else begin
               st_in[fbbf_pkg::ST_OUT].force_out[a] = 32'(-q);
            end
         end else begin
            if (st_ff[fbbf_pkg::ST_OUT-1].ovf[a] || q > 32'h7FFF_FFFF) begin
               st_in[fbbf_pkg::ST_OUT].force_out[a] = 32'h7FFF_FFFF;
            end else begin
               st_in[fbbf_pkg::ST_OUT].force_out[a] = q;
            end
         end
      end
   end

   // The last stage is the output register.
   assign rsp_tvalid = vld_ff[LAST];
   assign rsp_tdata  = {st_ff[LAST].energy, st_ff[LAST].force_out[2],
                        st_ff[LAST].force_out[1], st_ff[LAST].force_out[0]};
   assign rsp_tuser  = {st_ff[LAST].zero, st_ff[LAST].well};
   assign rsp_tlast  = st_ff[LAST].last;

endmodule

FILE: verif/flat_bottom_bond_force_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for flat_bottom_bond_force_core: bonds are streamed in,
// forces and energies are predicted in the bench and compared per result transfer.
// Depends on fbbf_pkg (register indexes, spin codes, special wall reset value) and the core RTL.
module flat_bottom_bond_force_core_tb;

   // One predicted result of the bond force pipeline.
   typedef struct {
      logic [31:0] fx, fy, fz;
      logic [31:0] energy;
      logic        well;
      logic        zero;
      logic        last;
   } bond_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [207:0]  req_tdata = '0;
   logic          req_tuser = 1'b0;
   logic          req_tlast = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [127:0]  rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          rsp_tlast;
   logic          csr_we = 1'b0;
   logic [2:0]    csr_addr = '0;
   logic [31:0]   csr_wdata = '0;

   // Drain waits outlast the depth of the core pipeline.
   localparam int PIPE_LATENCY = 80;
   localparam int CYCLE_LIMIT  = 400000;

   // Bench copy of the coefficient registers.
   logic [31:0] coeff_regs [0:6];

   bond_result_type pending_results [$];
   int unsigned  mismatch_count = 0;
   int unsigned  result_count = 0;
   int unsigned  bond_count = 0;
   int unsigned  cycle_count = 0;
   bit           stall_enable = 1'b1;

   flat_bottom_bond_force_core u_top (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // Watchdog: a stuck handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_results.size());
         $display("flat_bottom_bond_force_core test failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("mismatch at result %0d: %s got %h expected %h", result_count, what, got, want);
   endtask

   // Integer square root, rounded down, of a value below 2^68.
   function automatic logic [33:0] floor_sqrt(input logic [67:0] v);
      logic [33:0] root;
      logic [33:0] trial;
      root = '0;
      for (int b = 33; b >= 0; b--) begin
         trial = root | (34'd1 << b);
         if ({68'd0, trial} * {68'd0, trial} <= {68'd0, v}) root = trial;
      end
      return root;
   endfunction

   // Works out force, energy and flags of one bond from the bench registers.
   function automatic bond_result_type bond_force(input logic [207:0] data, input logic btype,
                                                  input logic last);
      bond_result_type res;
      logic signed [33:0] delta [3];
      logic [32:0]  mag [3];
      logic [67:0]  len_sq;
      logic [33:0]  bond_len;
      logic [31:0]  k, rmax, rmin;
      logic signed [7:0] spin_a, spin_b;
      logic signed [35:0] dr;
      logic [35:0]  adr;
      logic [255:0] wide, quo, den;
      logic [31:0]  force_vals [3];
      bit           neg;
      len_sq = '0;
      for (int i = 0; i < 3; i++) begin
         delta[i] = $signed(data[32*i +: 32]) - $signed(data[32*(i+3) +: 32]);
         mag[i] = delta[i] < 0 ? 33'(-delta[i]) : 33'(delta[i]);
         len_sq += {35'd0, mag[i]} * {35'd0, mag[i]};
      end
      bond_len = floor_sqrt(len_sq);
      k    = coeff_regs[btype ? fbbf_pkg::CSR_STIFFNESS_TYPE1  : fbbf_pkg::CSR_STIFFNESS_TYPE0];
      rmax = coeff_regs[btype ? fbbf_pkg::CSR_OUTER_WALL_TYPE1 : fbbf_pkg::CSR_OUTER_WALL_TYPE0];
      rmin = coeff_regs[btype ? fbbf_pkg::CSR_INNER_WALL_TYPE1 : fbbf_pkg::CSR_INNER_WALL_TYPE0];
      spin_a = data[199:192];
      spin_b = data[207:200];
      if (spin_a == fbbf_pkg::SPIN_POS_FOUR || spin_a == fbbf_pkg::SPIN_NEG_FOUR ||
          spin_b == fbbf_pkg::SPIN_POS_FOUR || spin_b == fbbf_pkg::SPIN_NEG_FOUR)
         rmax = coeff_regs[fbbf_pkg::CSR_SPECIAL_OUTER];
      res.well = 1'b0;
      dr = '0;
      if (bond_len < rmax && bond_len > rmin) res.well = 1'b1;
      else if (bond_len > rmax) dr = $signed({2'b0, bond_len}) - $signed({4'b0, rmax});
      else if (bond_len < rmin) dr = $signed({2'b0, bond_len}) - $signed({4'b0, rmin});
      adr = dr < 0 ? 36'(-dr) : 36'(dr);
      res.zero = (bond_len == 0);
      res.energy = '0;
      force_vals = '{default: '0};
      if (!res.well && adr != 0) begin
         wide = 256'(adr) * 256'(adr) * 256'(k);
         res.energy = (wide >> 32) > 256'hFFFF_FFFF ? 32'hFFFF_FFFF : wide[63:32];
         if (!res.zero) begin
            den = 256'(bond_len) << 15;
            for (int i = 0; i < 3; i++) begin
               if (mag[i] != 0) begin
                  quo = (256'(k) * 256'(adr) * 256'(mag[i])) / den;
                  // The force points back into the well: against del when stretched.
                  neg = (dr > 0) == (delta[i] > 0);
                  if (neg)
                     force_vals[i] = quo > 256'h8000_0000 ? 32'h8000_0000 : -quo[31:0];
                  else
                     force_vals[i] = quo > 256'h7FFF_FFFF ? 32'h7FFF_FFFF : quo[31:0];
               end
            end
         end
      end
      res.fx = force_vals[0];
      res.fy = force_vals[1];
      res.fz = force_vals[2];
      res.last = last;
      return res;
   endfunction

   // Drives one register write; the caller drops the write enable afterwards.
   task automatic write_coeff(input logic [2:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      coeff_regs[idx] = value;
   endtask

   // Waits until every predicted result has come back, then lets the pipe settle.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   // Loads one full coefficient set; only called with the pipeline empty.
   task automatic load_coeffs(input logic [31:0] k0, r0max, r0min, k1, r1max, r1min, rsp);
      wait_for_drain();
      write_coeff(fbbf_pkg::CSR_STIFFNESS_TYPE0, k0);
      write_coeff(fbbf_pkg::CSR_OUTER_WALL_TYPE0, r0max);
      write_coeff(fbbf_pkg::CSR_INNER_WALL_TYPE0, r0min);
      write_coeff(fbbf_pkg::CSR_STIFFNESS_TYPE1, k1);
      write_coeff(fbbf_pkg::CSR_OUTER_WALL_TYPE1, r1max);
      write_coeff(fbbf_pkg::CSR_INNER_WALL_TYPE1, r1min);
      write_coeff(fbbf_pkg::CSR_SPECIAL_OUTER, rsp);
      csr_we <= 1'b0;
   endtask

   // Sends one bond after a random gap; the prediction is queued at acceptance.
   // Valid stays high after a transfer until the next gap or drain drops it.
   task automatic send_bond(input logic [207:0] data, input logic btype, input logic last);
      int gap;
      gap = stall_enable ? $urandom_range(0, 17) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= btype;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(bond_force(data, btype, last));
      bond_count++;
   endtask

   // Receiver: random stall before each transfer, then compares field by field.
   initial begin
      bond_result_type want;
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = stall_enable ? $urandom_range(0, 17) : 0;
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         result_count++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result transfer", rsp_tdata[31:0], 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[31:0] !== want.fx) report_mismatch("force_x", rsp_tdata[31:0], want.fx);
            if (rsp_tdata[63:32] !== want.fy)
               report_mismatch("force_y", rsp_tdata[63:32], want.fy);
            if (rsp_tdata[95:64] !== want.fz)
               report_mismatch("force_z", rsp_tdata[95:64], want.fz);
            if (rsp_tdata[127:96] !== want.energy)
               report_mismatch("bond_energy", rsp_tdata[127:96], want.energy);
            if (rsp_tuser[0] !== want.well)
               report_mismatch("in_well", 32'(rsp_tuser[0]), 32'(want.well));
            if (rsp_tuser[1] !== want.zero)
               report_mismatch("zero_length", 32'(rsp_tuser[1]), 32'(want.zero));
            if (rsp_tlast !== want.last)
               report_mismatch("final_out", 32'(rsp_tlast), 32'(want.last));
         end
      end
   end

   function automatic logic [207:0] pack_bond(input logic [31:0] ax, ay, az, bx, by, bz,
                                              input logic [7:0] sa, sb);
      return {sb, sa, bz, by, bx, az, ay, ax};
   endfunction

   function automatic logic [7:0] random_spin();
      case ($urandom_range(0, 5))
         0: return fbbf_pkg::SPIN_POS_FOUR;
         1: return fbbf_pkg::SPIN_NEG_FOUR;
         2: return 8'($urandom);
         default: return 8'($urandom_range(0, 7) - 3);
      endcase
   endfunction

   // Second atom placed near the first, so lengths land around the wells.
   task automatic send_near_bond(input int unsigned reach);
      logic [31:0] ax, ay, az;
      ax = $urandom; ay = $urandom; az = $urandom;
      send_bond(pack_bond(ax, ay, az,
                          ax + $urandom_range(0, 2*reach) - reach,
                          ay + $urandom_range(0, 2*reach) - reach,
                          az + $urandom_range(0, 2*reach) - reach,
                          random_spin(), random_spin()),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // Directed: field extremes, coincident atoms, wall hits, spin override.
   task automatic test_directed();
      load_coeffs(32'h0001_0000, 32'h0002_0000, 32'h0001_0000,
                  32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_4000, 32'h0003_0000);
      send_bond(pack_bond(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, 1'b0);            // zero length
      send_bond(pack_bond(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b1);
      send_bond(pack_bond(32'h0002_0000, 0, 0, 0, 0, 0, 0, 0), 1'b0, 1'b0); // on outer wall
      send_bond(pack_bond(32'h0001_0000, 0, 0, 0, 0, 0, 0, 0), 1'b0, 1'b0); // on inner wall
      send_bond(pack_bond(32'h0001_8000, 0, 0, 0, 0, 0, 0, 0), 1'b0, 1'b0); // inside well
      send_bond(pack_bond(0, 32'h0003_0000, 0, 0, 0, 0, 8'sd4, 0), 1'b0, 1'b0);
      send_bond(pack_bond(0, 0, 32'h0002_8000, 0, 0, 0, 0, -8'sd4), 1'b0, 1'b0);
      send_bond(pack_bond(32'h0000_8000, 0, 0, 0, 0, 0, 8'h80, 8'h7F), 1'b0, 1'b0);
      send_bond(pack_bond(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'hFF, 8'h7F),
                1'b1, 1'b1);
      send_bond(pack_bond(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'h80, 8'h80),
                1'b0, 1'b0);
      send_bond(pack_bond(32'hFFFF_FFFF, 0, 0, 0, 32'h0000_0001, 0, 0, 0), 1'b1, 1'b0);
      send_bond(pack_bond(32'h0000_0010, 32'hFFFF_FFF0, 32'h0000_0001,
                          0, 0, 0, 0, 0), 1'b1, 1'b1);
      // Inverted walls and saturating stiffness on type 0.
      load_coeffs(32'hFFFF_FFFF, 32'h0000_1000, 32'h0010_0000,
                  32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      send_bond(pack_bond(32'h0000_0800, 0, 0, 0, 0, 0, 0, 0), 1'b0, 1'b0);
      send_bond(pack_bond(32'h0000_1000, 0, 0, 0, 0, 0, 0, 0), 1'b0, 1'b0);
      send_bond(pack_bond(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, 1'b0);
      send_bond(pack_bond(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 0, 0), 1'b0, 1'b0);
      send_bond(pack_bond(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 8'sd4, 0), 1'b1, 1'b0);
      send_bond(pack_bond(32'h0000_0800, 0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b1);
   endtask

   // Random bonds under a given coefficient set; mostly near the wells.
   task automatic test_random_phase(input int n, input int unsigned reach);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 4) == 0)
            send_bond({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom)},
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         else
            send_near_bond(reach);
      end
   endtask

   task automatic test_random();
      load_coeffs(32'h0001_0000, 32'h0003_0000, 32'h0001_0000,
                  32'h0000_4000, 32'h0004_0000, 32'h0000_8000, 32'h0002_0000);
      test_random_phase(400, 32'h0002_0000);
      // Hold off until the pipeline is empty, then resume.
      wait_for_drain();
      load_coeffs($urandom, $urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0008_0000),
                  $urandom, $urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0008_0000),
                  $urandom_range(0, 32'h0010_0000));
      test_random_phase(400, 32'h0008_0000);
      load_coeffs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                  32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      test_random_phase(300, 32'h4000_0000);
      load_coeffs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      test_random_phase(300, 32'h7FFF_FFFF);
   endtask

   // Back-to-back traffic with both sides always ready.
   task automatic test_full_rate();
      wait_for_drain();
      stall_enable = 1'b0;
      load_coeffs(32'h0002_0000, 32'h0002_0000, 32'h0000_8000,
                  32'h0000_8000, 32'h0001_0000, 32'h0000_0000, 32'h0000_8000);
      test_random_phase(280, 32'h0003_0000);
      stall_enable = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < 7; i++) coeff_regs[i] = '0;
      coeff_regs[fbbf_pkg::CSR_SPECIAL_OUTER] = fbbf_pkg::SPECIAL_OUTER_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Reset values first: zero walls and stiffness, but the special outer wall at 32768.
      send_bond(pack_bond(32'h0001_0000, 0, 0, 0, 0, 0, 8'sd4, 0), 1'b0, 1'b0);
      send_bond(pack_bond(0, 32'h0000_4000, 0, 0, 0, 0, 0, 0), 1'b1, 1'b1);
      test_directed();
      test_random();
      test_full_rate();
      wait_for_drain();
      $display("Sent %0d bonds and checked %0d results over several coefficient sets,",
               bond_count, result_count);
      $display("including wall hits, zero length, spin override and saturation.");
      if (mismatch_count == 0) begin
         $display("flat_bottom_bond_force_core test passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("flat_bottom_bond_force_core test failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/fbbf_pkg.sv
rtl/core/flat_bottom_bond_force_core.sv
verif/flat_bottom_bond_force_core_tb.sv
